// File: rtl/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 package
// Shared types, constants and byte-level round functions of the block cipher.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned NumKeys   = 11;
  localparam int unsigned LastRound = 10;
  localparam int unsigned KeyAw     = $clog2(NumKeys);
  localparam int unsigned BlockW    = 128;
  localparam int unsigned CntW      = $clog2(NumKeys + 1);

  localparam logic CFG_KEY_HIGH = 1'b0;
  localparam logic CFG_KEY_LOW  = 1'b1;
  localparam logic KIND_DEC     = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_ROUND
  } aes_state_e;

  typedef struct packed {
    logic        kind;
    logic [63:0] data_high;
    logic [63:0] data_low;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] out_high;
    logic [63:0] out_low;
  } aes_out_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rotl(input logic [7:0] x, input int unsigned n);
    return (x << n) | (x >> (8 - n));
  endfunction

  function automatic logic [7:0] inv_affine(input logic [7:0] s);
    return rotl(s, 1) ^ rotl(s, 3) ^ rotl(s, 6) ^ 8'h05;
  endfunction

  function automatic logic [7:0] sub_byte(input logic [7:0] x);
    return SBOX[x];
  endfunction

  function automatic logic [7:0] inv_sub_byte(input logic [7:0] s);
    return inv_affine(SBOX[inv_affine(s)]);
  endfunction

  function automatic logic [7:0] get_b(input logic [BlockW-1:0] s, input int unsigned i);
    return s[BlockW-1-8*i -: 8];
  endfunction

  function automatic logic [BlockW-1:0] sub_bytes(input logic [BlockW-1:0] s,
                                                  input logic inv);
    logic [BlockW-1:0] t;
    for (int i = 0; i < 16; i++) begin
      t[BlockW-1-8*i -: 8] = inv ? inv_sub_byte(get_b(s, i)) : sub_byte(get_b(s, i));
    end
    return t;
  endfunction

  function automatic logic [BlockW-1:0] shift_rows(input logic [BlockW-1:0] s,
                                                   input logic inv);
    logic [BlockW-1:0] t;
    int unsigned src;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        src = inv ? ((c - r + 4) & 3) : ((c + r) & 3);
        t[BlockW-1-8*(r+4*c) -: 8] = get_b(s, r + 4 * src);
      end
    end
    return t;
  endfunction

  function automatic logic [BlockW-1:0] mix_columns(input logic [BlockW-1:0] s,
                                                    input logic inv);
    logic [BlockW-1:0] t;
    logic [7:0] a [4];
    logic [7:0] a2 [4];
    logic [7:0] a4 [4];
    logic [7:0] a8 [4];
    logic [7:0] m9, m11, m13, m14;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        a[i]  = get_b(s, 4 * c + i);
        a2[i] = xtime(a[i]);
        a4[i] = xtime(a2[i]);
        a8[i] = xtime(a4[i]);
      end
      for (int i = 0; i < 4; i++) begin
        if (inv) begin
          m14 = a8[i] ^ a4[i] ^ a2[i];
          m11 = a8[(i+1)&3] ^ a2[(i+1)&3] ^ a[(i+1)&3];
          m13 = a8[(i+2)&3] ^ a4[(i+2)&3] ^ a[(i+2)&3];
          m9  = a8[(i+3)&3] ^ a[(i+3)&3];
          t[BlockW-1-8*(4*c+i) -: 8] = m14 ^ m11 ^ m13 ^ m9;
        end else begin
          t[BlockW-1-8*(4*c+i) -: 8] = a2[i] ^ a2[(i+1)&3] ^ a[(i+1)&3] ^
                                       a[(i+2)&3] ^ a[(i+3)&3];
        end
      end
    end
    return t;
  endfunction

  function automatic logic [BlockW-1:0] next_key(input logic [BlockW-1:0] k,
                                                 input logic [7:0] rcon);
    logic [31:0] t, w0, w1, w2, w3;
    t  = {sub_byte(get_b(k, 13)) ^ rcon, sub_byte(get_b(k, 14)),
          sub_byte(get_b(k, 15)), sub_byte(get_b(k, 12))};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

// File: rtl/aes_ram.sv
// ----------------------------------------------------------------------------
// AES generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module aes_ram #(
  parameter int unsigned Width = 128,
  parameter int unsigned Depth = 11
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/aes128_block_cipher.sv
// ----------------------------------------------------------------------------
// AES-128 block cipher
// One block at a time: the key expansion writes the round keys into the key
// RAM, then the shared round unit reads them back, one round key per cycle. busy
// is low again in the done cycle, so a new block can start there.
// Reset clears the key registers and the controller.
// ----------------------------------------------------------------------------
module aes128_block_cipher (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  aes_pkg::aes_in_t in_i,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [63:0]      cfg_data_i,
  output logic             done_o,
  output aes_pkg::aes_out_t out_o
);
  import aes_pkg::*;

  aes_state_e        state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [63:0]       key_high_q, key_low_q;
  logic [BlockW-1:0] s_q, s_d;
  logic [BlockW-1:0] k_q, k_d;
  logic [7:0]        rcon_q, rcon_d;
  logic              kind_q, kind_d;
  logic              done_q, done_d;
  logic              we;
  logic [KeyAw-1:0]  waddr, raddr;
  logic [BlockW-1:0] wdata, rkey, nk, t;
  logic [CntW-1:0]   j;
  logic              dec;

  aes_ram #(
    .Width(BlockW),
    .Depth(NumKeys)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rkey)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_KEY_HIGH) begin
        key_high_q <= cfg_data_i;
      end
      if (cfg_idx_i == CFG_KEY_LOW) begin
        key_low_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q    <= s_d;
    k_q    <= k_d;
    rcon_q <= rcon_d;
    kind_q <= kind_d;
  end

  assign nk  = next_key(k_q, rcon_q);
  assign dec = (kind_q == KIND_DEC);
  assign j   = cnt_q - CntW'(1);

  always_comb begin
    t = '0;
    if (j == '0) begin
      t = s_q ^ rkey;
    end else if (dec) begin
      t = sub_bytes(shift_rows(s_q, 1'b1), 1'b1) ^ rkey;
      if (j != CntW'(LastRound)) begin
        t = mix_columns(t, 1'b1);
      end
    end else begin
      t = shift_rows(sub_bytes(s_q, 1'b0), 1'b0);
      if (j != CntW'(LastRound)) begin
        t = mix_columns(t, 1'b0);
      end
      t = t ^ rkey;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    s_d     = s_q;
    k_d     = k_q;
    rcon_d  = rcon_q;
    kind_d  = kind_q;
    done_d  = 1'b0;
    we      = 1'b0;
    waddr   = cnt_q[KeyAw-1:0];
    wdata   = nk;
    raddr   = dec ? KeyAw'(LastRound) - cnt_q[KeyAw-1:0] : cnt_q[KeyAw-1:0];
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          we      = 1'b1;
          waddr   = '0;
          wdata   = {key_high_q, key_low_q};
          k_d     = {key_high_q, key_low_q};
          s_d     = {in_i.data_high, in_i.data_low};
          kind_d  = in_i.kind;
          rcon_d  = 8'h01;
          cnt_d   = CntW'(1);
          state_d = ST_EXPAND;
        end
      end
      ST_EXPAND: begin
        we     = 1'b1;
        k_d    = nk;
        rcon_d = xtime(rcon_q);
        if (cnt_q == CntW'(LastRound)) begin
          cnt_d   = '0;
          state_d = ST_ROUND;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      ST_ROUND: begin
        if (cnt_q != '0) begin
          s_d = t;
        end
        if (cnt_q == CntW'(NumKeys)) begin
          done_d  = 1'b1;
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy         = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign out_o.out_high = s_q[127:64];
  assign out_o.out_low  = s_q[63:0];

endmodule
